// ===== hw/rtl/rhp_pkg.sv =====
// Package for the RTP header parser: record kinds, parse phases and the result record type.
// Depends on nothing; used by rtp_header_parser.
package rhp_pkg;

  localparam int unsigned KindW    = 3;
  localparam int unsigned FixedLen = 12;
  localparam int unsigned PosW     = 4;
  localparam int unsigned SkipW    = 18;

  localparam logic [KindW-1:0] KIND_HEADER = 3'd0;
  localparam logic [KindW-1:0] KIND_CSRC   = 3'd1;
  localparam logic [KindW-1:0] KIND_BYTE   = 3'd2;
  localparam logic [KindW-1:0] KIND_EXT    = 3'd3;
  localparam logic [KindW-1:0] KIND_TRUNC  = 3'd4;

  typedef enum logic [4:0] {
    PH_FIXED   = 5'b00001,
    PH_CSRC    = 5'b00010,
    PH_EXTHDR  = 5'b00100,
    PH_SKIP    = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [31:0]      item_value;
    logic [31:0]      sync_source;
    logic [31:0]      time_stamp;
    logic [15:0]      sequence_number;
    logic [6:0]       payload_kind;
    logic             marker_bit;
    logic [3:0]       csrc_count;
    logic             extension_flag;
    logic             padding_flag;
    logic [1:0]       version;
  } rec_data_t;

endpackage

// ===== hw/rtl/rtp_header_parser.sv =====
// RTP header parser top level: splits a byte stream into header, CSRC, extension,
// payload and truncation records. Depends on rhp_pkg.
// Output: each record is registered and appears on the output register in the cycle after its byte is accepted.
// Throughput: one byte per cycle while the output register is empty or out_tready is high;
// the byte is parsed in the accept cycle and the output register holds the record while the next byte is taken.
// Reset: synchronous active-low rst_n clears the parse phase, counters and out_tvalid.
module rtp_header_parser (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // data_byte
  input  logic         in_tlast,   // end_of_packet
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // version, padding_flag, extension_flag, csrc_count,
                                   // marker_bit, payload_kind, sequence_number,
                                   // time_stamp, sync_source, item_value
  output logic [2:0]   out_tuser,  // kind
  output logic         out_tlast   // last_record
);

  rhp_pkg::phase_t               phase_r, phase_nxt;
  logic [rhp_pkg::PosW-1:0]      pos_r, pos_nxt, pos_inc;
  logic [63:0]                   hdr_r, hdr_nxt;
  logic [31:0]                   gather_r, gather_nxt;
  logic [3:0]                    srcs_r, srcs_nxt, srcs_dec;
  logic [15:0]                   prof_r, prof_nxt;
  logic [rhp_pkg::SkipW-1:0]     skip_r, skip_nxt, skip_dec;
  logic                          skip_end;

  logic                          rec_valid;
  logic [rhp_pkg::KindW-1:0]     rec_kind;
  rhp_pkg::rec_data_t            rec_data;
  logic                          rec_last;

  logic                          out_valid_r;
  logic [rhp_pkg::KindW-1:0]     out_kind_r;
  rhp_pkg::rec_data_t            out_data_r;
  logic                          out_last_r;

  logic                          in_acc;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    hdr_nxt    = hdr_r;
    gather_nxt = gather_r;
    srcs_nxt   = srcs_r;
    prof_nxt   = prof_r;
    skip_nxt   = skip_r;
    pos_inc    = pos_r + 1'b1;
    srcs_dec   = srcs_r - 1'b1;
    skip_dec   = skip_r - 1'b1;
    skip_end   = 1'b0;
    rec_valid  = 1'b0;
    rec_kind   = rhp_pkg::KIND_HEADER;
    rec_data   = '0;
    rec_last   = 1'b0;

    case (phase_r)
      rhp_pkg::PH_CSRC: begin
        gather_nxt = {gather_r[23:0], in_tdata};
        pos_nxt    = pos_inc;
        if (pos_inc == rhp_pkg::PosW'(4)) begin
          rec_valid           = 1'b1;
          rec_kind            = rhp_pkg::KIND_CSRC;
          rec_data.item_value = gather_nxt;
          srcs_nxt            = srcs_dec;
          pos_nxt             = '0;
          gather_nxt          = '0;
          if (srcs_dec == 4'd0) begin
            phase_nxt = hdr_r[60] ? rhp_pkg::PH_EXTHDR : rhp_pkg::PH_PAYLOAD;
          end
        end
      end
      rhp_pkg::PH_EXTHDR: begin
        if (pos_r < rhp_pkg::PosW'(2)) begin
          prof_nxt = {prof_r[7:0], in_tdata};
        end else begin
          gather_nxt = {16'd0, gather_r[7:0], in_tdata};
        end
        pos_nxt = pos_inc;
        if (pos_inc == rhp_pkg::PosW'(4)) begin
          rec_valid           = 1'b1;
          rec_kind            = rhp_pkg::KIND_EXT;
          rec_data.item_value = {prof_nxt, gather_nxt[15:0]};
          skip_nxt            = {gather_nxt[15:0], 2'b00};
          phase_nxt           = (gather_nxt[15:0] != 16'd0) ? rhp_pkg::PH_SKIP
                                                            : rhp_pkg::PH_PAYLOAD;
          pos_nxt             = '0;
          gather_nxt          = '0;
        end
      end
      rhp_pkg::PH_SKIP: begin
        skip_nxt = skip_dec;
        if (skip_dec == '0) begin
          phase_nxt = rhp_pkg::PH_PAYLOAD;
          skip_end  = 1'b1;
        end
      end
      rhp_pkg::PH_PAYLOAD: begin
        rec_valid           = 1'b1;
        rec_kind            = rhp_pkg::KIND_BYTE;
        rec_data.item_value = {24'd0, in_tdata};
      end
      default: begin
        if (pos_r < rhp_pkg::PosW'(8)) begin
          hdr_nxt = {hdr_r[55:0], in_tdata};
        end else begin
          gather_nxt = {gather_r[23:0], in_tdata};
        end
        pos_nxt = pos_inc;
        if (pos_inc == rhp_pkg::PosW'(rhp_pkg::FixedLen)) begin
          rec_valid                = 1'b1;
          rec_kind                 = rhp_pkg::KIND_HEADER;
          rec_data.version         = hdr_nxt[63:62];
          rec_data.padding_flag    = hdr_nxt[61];
          rec_data.extension_flag  = hdr_nxt[60];
          rec_data.csrc_count      = hdr_nxt[59:56];
          rec_data.marker_bit      = hdr_nxt[55];
          rec_data.payload_kind    = hdr_nxt[54:48];
          rec_data.sequence_number = hdr_nxt[47:32];
          rec_data.time_stamp      = hdr_nxt[31:0];
          rec_data.sync_source     = gather_nxt;
          srcs_nxt                 = hdr_nxt[59:56];
          pos_nxt                  = '0;
          gather_nxt               = '0;
          if (hdr_nxt[59:56] != 4'd0) begin
            phase_nxt = rhp_pkg::PH_CSRC;
          end else begin
            phase_nxt = hdr_nxt[60] ? rhp_pkg::PH_EXTHDR : rhp_pkg::PH_PAYLOAD;
          end
        end else begin
          phase_nxt = rhp_pkg::PH_FIXED;
        end
      end
    endcase

    if (in_tlast) begin
      if (skip_end) begin
        rec_valid = 1'b0;
      end else if (!rec_valid) begin
        rec_valid = 1'b1;
        rec_kind  = rhp_pkg::KIND_TRUNC;
        rec_data  = '0;
      end
      rec_last   = 1'b1;
      phase_nxt  = rhp_pkg::PH_FIXED;
      pos_nxt    = '0;
      hdr_nxt    = '0;
      gather_nxt = '0;
      srcs_nxt   = '0;
      prof_nxt   = '0;
      skip_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= rhp_pkg::PH_FIXED;
      pos_r    <= '0;
      hdr_r    <= '0;
      gather_r <= '0;
      srcs_r   <= '0;
      prof_r   <= '0;
      skip_r   <= '0;
    end else if (in_acc) begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      hdr_r    <= hdr_nxt;
      gather_r <= gather_nxt;
      srcs_r   <= srcs_nxt;
      prof_r   <= prof_nxt;
      skip_r   <= skip_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= rec_valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_kind_r <= rec_kind;
      out_data_r <= rec_data;
      out_last_r <= rec_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule
